@@ rtl/fss_pkg.sv @@
// shared types and constants for the fp16 sum checksum block
// no dependencies; imported by every rtl module of the block except fss_checker
package fss_pkg;

    localparam int FSS_QUEUE_DEPTH = 4;

    localparam logic [63:0] FSS_QUIET64       = 64'h0008_0000_0000_0000;
    localparam logic [63:0] FSS_DEFAULT_NAN64 = 64'h7FF8_0000_0000_0000;
    localparam logic [10:0] FSS_EXP64_ONES    = 11'h7FF;
    localparam logic [7:0]  FSS_EXP32_ONES    = 8'hFF;

    // one widened element waiting for the accumulator
    typedef struct packed {
        logic [63:0] value;
        logic        last;
    } fss_word_t;

    // request to the shared binary64 adder
    typedef struct packed {
        logic        start;
        logic        sub;
        logic [63:0] a;
        logic [63:0] b;
    } fss_add_req_t;

    function automatic logic fss_is_nan64(input logic [63:0] u);
        return (u[62:52] == FSS_EXP64_ONES) && (u[51:0] != 52'd0);
    endfunction

endpackage

@@ rtl/fss_front.sv @@
// front end: accepts binary16 words and widens them exactly to binary64
// depends on fss_pkg
module fss_front
    import fss_pkg::*;
(
    input  logic      [15:0] half_bits,
    input  logic             last,
    output fss_word_t        word
);

    localparam logic [10:0] NormRebias = 11'd1008;
    localparam logic [10:0] SubBase    = 11'd1009;

    logic        sgn;
    logic [4:0]  ex;
    logic [9:0]  man;
    logic [3:0]  top_bit;
    logic [3:0]  shift;
    logic [9:0]  man_norm;

    assign sgn = half_bits[15];
    assign ex  = half_bits[14:10];
    assign man = half_bits[9:0];

    always_comb
    begin
        top_bit = 4'd0;
        for (int i = 0; i < 10; i++)
        begin
            if (man[i])
            begin
                top_bit = 4'(i);
            end
        end
    end

    assign shift    = 4'd10 - top_bit;
    assign man_norm = man << shift;

    always_comb
    begin
        word.last = last;
        if (ex == 5'd0)
        begin
            if (man == 10'd0)
            begin
                word.value = {sgn, 63'd0};
            end
            else
            begin
                word.value = {sgn, SubBase - {7'd0, shift}, man_norm, 42'd0};
            end
        end
        else if (ex == 5'h1F)
        begin
            word.value = {sgn, FSS_EXP64_ONES, man, 42'd0};
        end
        else
        begin
            word.value = {sgn, {6'd0, ex} + NormRebias, man, 42'd0};
        end
    end

endmodule

@@ rtl/fss_queue.sv @@
// short queue of widened words between front and back
// depends on fss_pkg
module fss_queue
    import fss_pkg::*;
#(
    parameter int DEPTH = FSS_QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  fss_word_t push_word,
    output logic      full,
    input  logic      pop,
    output logic      empty,
    output fss_word_t head
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

    fss_word_t           mem_reg [DEPTH];
    logic [PtrW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]     cnt_reg, cnt_next;

    assign full  = (cnt_reg == CntW'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

@@ rtl/fss_fadd.sv @@
// four stage binary64 adder/subtractor, round to nearest even
// depends on fss_pkg
module fss_fadd
    import fss_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  fss_add_req_t req,
    output logic         done,
    output logic [63:0]  res
);

    // stage a: specials, swap, exponent difference
    logic        a_v_reg;
    logic        a_spec_reg;
    logic [63:0] a_spec_val_reg;
    logic        a_sign_reg, a_esub_reg;
    logic [11:0] a_exp_reg;
    logic [52:0] a_mbig_reg, a_msml_reg;
    logic [10:0] a_diff_reg;

    logic [63:0] opb;
    logic        nan_a, nan_b, inf_a, inf_b, swap;
    logic [63:0] big, sml;
    logic [10:0] ebig, esml;

    assign opb   = {req.b[63] ^ req.sub, req.b[62:0]};
    assign nan_a = fss_is_nan64(req.a);
    assign nan_b = fss_is_nan64(req.b);
    assign inf_a = (req.a[62:52] == FSS_EXP64_ONES) && (req.a[51:0] == 52'd0);
    assign inf_b = (req.b[62:52] == FSS_EXP64_ONES) && (req.b[51:0] == 52'd0);
    assign swap  = opb[62:0] > req.a[62:0];
    assign big   = swap ? opb : req.a;
    assign sml   = swap ? req.a : opb;
    assign ebig  = (big[62:52] == 11'd0) ? 11'd1 : big[62:52];
    assign esml  = (sml[62:52] == 11'd0) ? 11'd1 : sml[62:52];

    always_ff @(posedge clk)
    begin
        a_spec_reg     <= nan_a || nan_b || inf_a || inf_b;
        a_sign_reg     <= big[63];
        a_esub_reg     <= big[63] ^ sml[63];
        a_exp_reg      <= {1'b0, ebig};
        a_mbig_reg     <= {big[62:52] != 11'd0, big[51:0]};
        a_msml_reg     <= {sml[62:52] != 11'd0, sml[51:0]};
        a_diff_reg     <= ebig - esml;
        priority if (nan_a)
            a_spec_val_reg <= req.a | FSS_QUIET64;
        else if (nan_b)
            a_spec_val_reg <= req.b | FSS_QUIET64;
        else if (inf_a && inf_b && (req.a[63] != opb[63]))
            a_spec_val_reg <= FSS_DEFAULT_NAN64;
        else if (inf_a)
            a_spec_val_reg <= req.a;
        else
            a_spec_val_reg <= opb;
    end

    // stage b: align and add
    logic        b_v_reg, b_spec_reg, b_sign_reg, b_esub_reg;
    logic [63:0] b_spec_val_reg;
    logic [11:0] b_exp_reg;
    logic [56:0] b_sum_reg;

    logic [5:0]  dclip;
    logic [63:0] sml_ext, sml_sh, sml_mask;
    logic [55:0] aligned;
    logic        align_st;

    assign dclip    = (a_diff_reg > 11'd63) ? 6'd63 : a_diff_reg[5:0];
    assign sml_ext  = {8'd0, a_msml_reg, 3'd0};
    assign sml_sh   = sml_ext >> dclip;
    assign sml_mask = (64'd1 << dclip) - 64'd1;
    assign align_st = |(sml_ext & sml_mask);
    assign aligned  = {sml_sh[55:1], sml_sh[0] | align_st};

    always_ff @(posedge clk)
    begin
        b_spec_reg     <= a_spec_reg;
        b_spec_val_reg <= a_spec_val_reg;
        b_sign_reg     <= a_sign_reg;
        b_esub_reg     <= a_esub_reg;
        b_exp_reg      <= a_exp_reg;
        b_sum_reg      <= a_esub_reg ? {1'b0, a_mbig_reg, 3'd0} - {1'b0, aligned}
                                     : {1'b0, a_mbig_reg, 3'd0} + {1'b0, aligned};
    end

    // stage c: leading zero count
    logic        c_v_reg, c_spec_reg, c_sign_reg, c_esub_reg;
    logic [63:0] c_spec_val_reg;
    logic [11:0] c_exp_reg;
    logic [56:0] c_sum_reg;
    logic [5:0]  c_lz_reg;
    logic [5:0]  lz;

    always_comb
    begin
        lz = 6'd56;
        for (int i = 0; i < 56; i++)
        begin
            if (b_sum_reg[i])
            begin
                lz = 6'(55 - i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        c_spec_reg     <= b_spec_reg;
        c_spec_val_reg <= b_spec_val_reg;
        c_sign_reg     <= b_sign_reg;
        c_esub_reg     <= b_esub_reg;
        c_exp_reg      <= b_exp_reg;
        c_sum_reg      <= b_sum_reg;
        c_lz_reg       <= lz;
    end

    // stage d: normalize, round, pack
    logic        d_v_reg;
    logic [63:0] d_res_reg;
    logic [11:0] lim, e_norm;
    logic [5:0]  nsh;
    logic [55:0] norm;
    logic [52:0] m53;
    logic        rnd_up;
    logic [62:0] packed_mag;
    logic [63:0] d_val;

    assign lim = c_exp_reg - 12'd1;

    always_comb
    begin
        nsh = (12'(c_lz_reg) > lim) ? lim[5:0] : c_lz_reg;
        if (c_sum_reg[56])
        begin
            norm   = {c_sum_reg[56:2], c_sum_reg[1] | c_sum_reg[0]};
            e_norm = c_exp_reg + 12'd1;
        end
        else
        begin
            norm   = c_sum_reg[55:0] << nsh;
            e_norm = c_exp_reg - 12'(nsh);
        end
        m53        = norm[55:3];
        rnd_up     = norm[2] && (norm[1] || norm[0] || m53[0]);
        packed_mag = {e_norm[10:0] - 11'd1, 52'd0} + {10'd0, m53} + {62'd0, rnd_up};
        priority if (c_spec_reg)
            d_val = c_spec_val_reg;
        else if (c_sum_reg == 57'd0)
            d_val = {c_sign_reg & ~c_esub_reg, 63'd0};
        else if (e_norm >= 12'd2047)
            d_val = {c_sign_reg, FSS_EXP64_ONES, 52'd0};
        else
            d_val = {c_sign_reg, packed_mag};
    end

    always_ff @(posedge clk)
    begin
        d_res_reg <= d_val;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
            d_v_reg <= 1'b0;
        end
        else
        begin
            a_v_reg <= req.start;
            b_v_reg <= a_v_reg;
            c_v_reg <= b_v_reg;
            d_v_reg <= c_v_reg;
        end
    end

    assign done = d_v_reg;
    assign res  = d_res_reg;

endmodule

@@ rtl/fss_back.sv @@
// back end: accumulates queued words, forms sum and narrowed difference
// depends on fss_pkg and fss_fadd
module fss_back
    import fss_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            expected_checksum_we,
    input  logic [63:0]     expected_checksum_wdata,
    input  logic            empty,
    input  fss_word_t       head,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [63:0]     out_sum,
    output logic [31:0]     out_diff
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_ADD    = 2'd1;
    localparam logic [1:0] S_SUB    = 2'd2;
    localparam logic [1:0] S_NARROW = 2'd3;

    logic [1:0]   state_reg, state_next;
    logic [63:0]  sum_reg, sum_next;
    logic         cur_last_reg, cur_last_next;
    logic [63:0]  diff_reg;
    logic [63:0]  expected_reg;
    logic         out_valid_reg, out_valid_next;
    logic [63:0]  out_sum_reg;
    logic [31:0]  out_diff_reg;
    logic         out_load;

    fss_add_req_t req;
    logic         add_done;
    logic [63:0]  add_res;

    fss_fadd u_fadd (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req),
        .done (add_done),
        .res  (add_res)
    );

    always_comb
    begin
        state_next    = state_reg;
        sum_next      = sum_reg;
        cur_last_next = cur_last_reg;
        pop           = 1'b0;
        out_load      = 1'b0;
        req.start     = 1'b0;
        req.sub       = 1'b0;
        req.a         = sum_reg;
        req.b         = head.value;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!empty)
                begin
                    pop           = 1'b1;
                    req.start     = 1'b1;
                    cur_last_next = head.last;
                    state_next    = S_ADD;
                end
            end
            S_ADD:
            begin
                if (add_done)
                begin
                    sum_next = add_res;
                    req.a    = add_res;
                    if (cur_last_reg)
                    begin
                        req.start  = 1'b1;
                        req.sub    = 1'b1;
                        req.b      = expected_reg;
                        state_next = S_SUB;
                    end
                    else if (!empty)
                    begin
                        // chain the next word straight off the adder result
                        pop           = 1'b1;
                        req.start     = 1'b1;
                        cur_last_next = head.last;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_SUB:
            begin
                if (add_done)
                begin
                    state_next = S_NARROW;
                end
            end
            S_NARROW:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    sum_next   = 64'd0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = out_load || (out_valid_reg && !out_ready);

    // binary64 to binary32, nearest even
    logic [10:0]        dexp;
    logic signed [12:0] e32;
    logic signed [12:0] neg_sh;
    logic [5:0]         nsh;
    logic [63:0]        mant, mant_sh, mant_mask;
    logic [23:0]        q;
    logic               g, st, up;
    logic [7:0]         eb;
    logic [30:0]        pk;
    logic [31:0]        narrow;

    assign dexp   = diff_reg[62:52];
    assign e32    = $signed({2'b00, dexp}) - 13'sd896;
    assign neg_sh = 13'sd1 - e32;

    always_comb
    begin
        if (e32 >= 13'sd1)
            nsh = 6'd0;
        else if (neg_sh > 13'sd63)
            nsh = 6'd63;
        else
            nsh = neg_sh[5:0];
        mant      = {11'd0, 1'b1, diff_reg[51:0]};
        mant_sh   = mant >> nsh;
        mant_mask = (64'd1 << nsh) - 64'd1;
        q         = mant_sh[52:29];
        g         = mant_sh[28];
        st        = (|mant_sh[27:0]) || (|(mant & mant_mask));
        up        = g && (st || q[0]);
        eb        = (e32 >= 13'sd1) ? 8'(e32 - 13'sd1) : 8'd0;
        pk        = {eb, 23'd0} + {7'd0, q} + {30'd0, up};
        priority if (fss_is_nan64(diff_reg))
            narrow = {diff_reg[63], FSS_EXP32_ONES, 1'b1, diff_reg[50:29]};
        else if (dexp == FSS_EXP64_ONES)
            narrow = {diff_reg[63], FSS_EXP32_ONES, 23'd0};
        else if (dexp == 11'd0)
            narrow = {diff_reg[63], 31'd0};
        else if (e32 >= 13'sd255)
            narrow = {diff_reg[63], FSS_EXP32_ONES, 23'd0};
        else
            narrow = {diff_reg[63], pk};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sum_reg       <= 64'd0;
            cur_last_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            expected_reg  <= 64'd0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            cur_last_reg  <= cur_last_next;
            out_valid_reg <= out_valid_next;
            if (expected_checksum_we)
            begin
                expected_reg <= expected_checksum_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_SUB && add_done)
        begin
            diff_reg <= add_res;
        end
        if (out_load)
        begin
            out_sum_reg  <= sum_reg;
            out_diff_reg <= narrow;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_sum   = out_sum_reg;
    assign out_diff  = out_diff_reg;

endmodule

@@ rtl/fp16_sum_checksum_check.sv @@
// top level of the fp16 sum checksum block
// depends on fss_pkg, fss_front, fss_queue, fss_back (which holds fss_fadd)
//
// input stream s_axis: one binary16 word per transfer, tlast marks the
// final word of a buffer. every word is widened to binary64 and added into
// a running binary64 sum. on the word with tlast the block sends one word on
// m_axis: the binary64 sum and the binary32 rounding of sum minus
// expected_checksum, then clears the sum to +0.
// the four stage binary64 adder is shared and loop-carried, so the next word is
// accumulated only once the previous add has come back; a queue of QUEUE_DEPTH
// words absorbs bursts, s_axis_tready drops only when it is full.
// from an accepted tlast word the result passes the last add, the subtract, the
// narrowing and the output register before m_axis_tvalid. a result waiting on
// m_axis does not stop input; accumulation continues until the next buffer's
// result needs the output register. reset clears the sum and expected_checksum
// to +0 and empties the queue. the user must write expected_checksum with
// expected_checksum_we only while idle; the block does not enforce it.
module fp16_sum_checksum_check
    import fss_pkg::*;
#(
    parameter int QUEUE_DEPTH = FSS_QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        expected_checksum_we,
    input  logic [63:0] expected_checksum_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] half_bits
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata    // [63:0] sum_bits, [95:64] difference_bits
);

    fss_word_t  in_word;
    fss_word_t  head;
    logic       full, empty, pop, push;
    logic [63:0] sum_bits;
    logic [31:0] difference_bits;

    fss_front u_front (
        .half_bits(s_axis_tdata),
        .last     (s_axis_tlast),
        .word     (in_word)
    );

    assign s_axis_tready = !full;
    assign push          = s_axis_tvalid && !full;

    fss_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_word(in_word),
        .full     (full),
        .pop      (pop),
        .empty    (empty),
        .head     (head)
    );

    fss_back u_back (
        .clk                    (clk),
        .rst_n                  (rst_n),
        .expected_checksum_we   (expected_checksum_we),
        .expected_checksum_wdata(expected_checksum_wdata),
        .empty                  (empty),
        .head                   (head),
        .pop                    (pop),
        .out_valid              (m_axis_tvalid),
        .out_ready              (m_axis_tready),
        .out_sum                (sum_bits),
        .out_diff               (difference_bits)
    );

    assign m_axis_tdata = {difference_bits, sum_bits};

endmodule

@@ rtl/fss_checker.sv @@
// port level checks for fp16_sum_checksum_check
// depends on nothing; bound to the top level below
module fss_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [95:0] m_axis_tdata
);

    logic sum_nan, sum_inf, diff_exp_ones;
    logic       last_acc, out_acc;
    logic [7:0] open_last_reg, open_last_next;

    assign sum_nan       = (m_axis_tdata[62:52] == 11'h7FF) && (m_axis_tdata[51:0] != 52'd0);
    assign sum_inf       = (m_axis_tdata[62:52] == 11'h7FF) && (m_axis_tdata[51:0] == 52'd0);
    assign diff_exp_ones = (m_axis_tdata[94:87] == 8'hFF);

    // last words accepted whose result word has not gone out yet
    assign last_acc       = s_axis_tvalid && s_axis_tready && s_axis_tlast;
    assign out_acc        = m_axis_tvalid && m_axis_tready;
    assign open_last_next = open_last_reg + 8'(last_acc) - 8'(out_acc);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_last_reg <= 8'd0;
        end
        else
        begin
            open_last_reg <= open_last_next;
        end
    end

    // stalled result stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped or changed while stalled");

    // every result word answers an earlier accepted last word
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (open_last_reg != 8'd0))
    else $error("result without a pending last word");

    // a nan sum propagates as a quiet nan difference
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && sum_nan |-> diff_exp_ones && m_axis_tdata[86])
    else $error("nan sum gave non nan difference");

    // an infinite sum leaves the difference infinite or nan
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && sum_inf |-> diff_exp_ones)
    else $error("infinite sum gave finite difference");

endmodule

bind fp16_sum_checksum_check fss_checker u_fss_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
);

@@ tb/sv/fp16_sum_checksum_check_test.sv @@
// self-checking testbench for fp16_sum_checksum_check: binary16 words summed in binary64
// depends on the rtl top level; predicts sum and binary32 difference per buffer
module fp16_sum_checksum_check_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 30;

    typedef struct packed {
        logic [15:0] half_bits;
        logic        last;
    } half_word_t;

    typedef struct packed {
        logic [63:0] sum_bits;
        logic [31:0] difference_bits;
    } checksum_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        expected_checksum_we = 1'b0;
    logic [63:0] expected_checksum_wdata = 64'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = 16'd0;   // [15:0] half_bits
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [95:0] m_axis_tdata;           // [63:0] sum_bits, [95:64] difference_bits

    half_word_t       pending_words[$];
    checksum_result_t expected_results[$];
    logic [63:0]      running_sum = 64'd0;
    logic [63:0]      checksum_reg = 64'd0;
    int               cycle_count = 0;
    int               mismatch_count = 0;
    bit               sender_hold = 1'b0;

    fp16_sum_checksum_check uut (
        .clk                     (clk),
        .rst_n                   (rst_n),
        .expected_checksum_we    (expected_checksum_we),
        .expected_checksum_wdata (expected_checksum_wdata),
        .s_axis_tvalid           (s_axis_tvalid),
        .s_axis_tready           (s_axis_tready),
        .s_axis_tdata            (s_axis_tdata),
        .s_axis_tlast            (s_axis_tlast),
        .m_axis_tvalid           (m_axis_tvalid),
        .m_axis_tready           (m_axis_tready),
        .m_axis_tdata            (m_axis_tdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic is_nan64(input logic [63:0] u);
        return (u[62:52] == 11'h7FF) && (u[51:0] != 52'd0);
    endfunction

    function automatic logic [63:0] widen_half(input logic [15:0] h);
        logic [63:0] sign;
        logic [4:0]  e;
        logic [10:0] m;
        int          shift;
        sign = {h[15], 63'd0};
        e = h[14:10];
        m = {1'b0, h[9:0]};
        shift = 0;
        if (e == 5'd0)
        begin
            if (m == 11'd0)
                return sign;
            while (m[10] == 1'b0)
            begin
                m = m << 1;
                shift++;
            end
            return sign | (64'(1009 - shift) << 52) | (64'(m[9:0]) << 42);
        end
        if (e == 5'h1F)
            return sign | (64'h7FF << 52) | (64'(m[9:0]) << 42);
        return sign | (64'(e + 1008) << 52) | (64'(m[9:0]) << 42);
    endfunction

    // ieee add or subtract with the block's nan rules
    function automatic logic [63:0] add64(input logic [63:0] a, input logic [63:0] b,
                                          input bit subtract);
        real         r;
        logic [63:0] rb;
        if (is_nan64(a))
            return a | 64'h0008_0000_0000_0000;
        if (is_nan64(b))
            return b | 64'h0008_0000_0000_0000;
        r = subtract ? $bitstoreal(a) - $bitstoreal(b) : $bitstoreal(a) + $bitstoreal(b);
        rb = $realtobits(r);
        if (is_nan64(rb))
            return 64'h7FF8_0000_0000_0000;
        return rb;
    endfunction

    // binary64 to binary32, nearest even, subnormals kept
    function automatic logic [31:0] narrow64(input logic [63:0] u);
        logic [31:0] sign;
        logic [63:0] m;
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] half;
        int          exp_unb;
        int          sh;
        int          field;
        sign = {u[63], 31'd0};
        if (is_nan64(u))
            return sign | 32'h7FC0_0000 | 32'(u[50:29]);
        if (u[62:52] == 11'h7FF)
            return sign | 32'h7F80_0000;
        if (u[62:0] == 63'd0)
            return sign;
        m = (u[62:52] == 11'd0) ? {12'd0, u[51:0]} : {11'd0, 1'b1, u[51:0]};
        exp_unb = (u[62:52] == 11'd0) ? -1022 : int'(u[62:52]) - 1023;
        if (exp_unb > 127)
            return sign | 32'h7F80_0000;
        sh = (exp_unb >= -126) ? 29 : 29 + (-126 - exp_unb);
        if (sh >= 55)
            return sign;
        field = (exp_unb >= -126) ? exp_unb + 126 : 0;
        q = m >> sh;
        rem = m & ((64'd1 << sh) - 64'd1);
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && q[0]))
            q = q + 64'd1;
        // hidden bit carries into the exponent field, overflow lands on infinity
        return sign | 32'((64'(field) << 23) + q);
    endfunction

    task automatic accumulate_word(input half_word_t w);
        checksum_result_t res;
        running_sum = add64(running_sum, widen_half(w.half_bits), 1'b0);
        if (w.last)
        begin
            res.sum_bits = running_sum;
            res.difference_bits = narrow64(add64(running_sum, checksum_reg, 1'b1));
            expected_results.push_back(res);
            running_sum = 64'd0;
        end
    endtask

    function automatic bit idle_roll();
        // quiet stretch with no idling on either side
        if (cycle_count > 3000 && cycle_count < 6000)
            return 1'b0;
        return $urandom_range(0, 99) < 13;
    endfunction

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // input driver
    always @(posedge clk)
    begin
        half_word_t w;
        if (rst_n && (!s_axis_tvalid || s_axis_tready))
        begin
            if (s_axis_tvalid)
                accumulate_word('{s_axis_tdata, s_axis_tlast});
            if (pending_words.size() > 0 && !sender_hold && !idle_roll())
            begin
                w = pending_words.pop_front();
                s_axis_tdata <= w.half_bits;
                s_axis_tlast <= w.last;
                s_axis_tvalid <= 1'b1;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // output monitor
    always @(posedge clk)
    begin
        checksum_result_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result word: sum %h diff %h",
                                 m_axis_tdata[63:0], m_axis_tdata[95:64]);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (m_axis_tdata[63:0] !== want.sum_bits ||
                        m_axis_tdata[95:64] !== want.difference_bits)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: sum exp %h got %h, diff exp %h got %h",
                                     want.sum_bits, m_axis_tdata[63:0],
                                     want.difference_bits, m_axis_tdata[95:64]);
                    end
                end
            end
            m_axis_tready <= !idle_roll();
        end
    end

    always @(posedge clk)
    begin
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic logic [15:0] random_half();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 2)
            return {1'($urandom), 5'h1F, 10'($urandom)};
        if (pick < 12)
            return {1'($urandom), 5'h00, 10'($urandom)};
        return {1'($urandom), 5'($urandom_range(0, 30)), 10'($urandom)};
    endfunction

    task automatic queue_buffer(input int len);
        for (int i = 0; i < len; i++)
            pending_words.push_back('{random_half(), i == len - 1});
    endtask

    task automatic wait_drained();
        while (pending_words.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_checksum(input logic [63:0] value);
        @(posedge clk);
        expected_checksum_we <= 1'b1;
        expected_checksum_wdata <= value;
        checksum_reg = value;
        @(posedge clk);
        expected_checksum_we <= 1'b0;
    endtask

    initial
    begin
        logic [63:0] checksums[8];
        int          fed;
        checksums = '{64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
                      64'h7FF0_0000_0000_0000, 64'h3FF0_0000_0000_0000,
                      64'h0000_0000_0000_0001, 64'hC7EF_FFFF_F000_0000,
                      64'h40F0_0000_0000_0000, 64'h0};
        checksums[7] = {$urandom, $urandom};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: zeros, subnormal edges, normal edges, infinities, nans
        pending_words.push_back('{16'h0000, 1'b1});
        pending_words.push_back('{16'h8000, 1'b1});
        pending_words.push_back('{16'h8000, 1'b0});
        pending_words.push_back('{16'h0000, 1'b1});
        pending_words.push_back('{16'h0001, 1'b0});
        pending_words.push_back('{16'h03FF, 1'b0});
        pending_words.push_back('{16'h0400, 1'b1});
        pending_words.push_back('{16'h7BFF, 1'b0});
        pending_words.push_back('{16'hFBFF, 1'b0});
        pending_words.push_back('{16'h3C00, 1'b1});
        pending_words.push_back('{16'h7C00, 1'b1});
        pending_words.push_back('{16'hFC00, 1'b0});
        pending_words.push_back('{16'h7C00, 1'b1});
        pending_words.push_back('{16'h7C01, 1'b0});
        pending_words.push_back('{16'h3C00, 1'b1});
        pending_words.push_back('{16'hFFFF, 1'b1});
        pending_words.push_back('{16'h7E00, 1'b0});
        pending_words.push_back('{16'hFE01, 1'b1});
        pending_words.push_back('{16'h8001, 1'b1});
        wait_drained();

        // pause the sender while a six-word buffer is queued, then resume
        sender_hold = 1'b1;
        queue_buffer(6);
        repeat (50) @(posedge clk);
        sender_hold = 1'b0;
        wait_drained();

        foreach (checksums[p])
        begin
            write_checksum(checksums[p]);
            fed = 0;
            while (fed < 190)
            begin
                int len;
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 8);
                queue_buffer(len);
                fed += len;
            end
            wait_drained();
        end

        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ fp16_sum_checksum_check.f @@
rtl/fss_pkg.sv
rtl/fss_front.sv
rtl/fss_queue.sv
rtl/fss_fadd.sv
rtl/fss_back.sv
rtl/fp16_sum_checksum_check.sv
rtl/fss_checker.sv
tb/sv/fp16_sum_checksum_check_test.sv
